/* rtl/core/http_request_head_parser_unit_assert.svh */
// Assertion macros shared by the request head parser RTL.
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on i_clk, off while in reset.
`define HRHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrhp: same-cycle check failed");

// Next-cycle implication, checked on i_clk, off while in reset.
`define HRHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrhp: next-cycle check failed");

`endif

/* rtl/core/hrhp_pkg.sv */
// Shared types and constants of the request head parser.
`default_nettype none
package hrhp_pkg;

    localparam int unsigned LEN_W = 11;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [3:0][7:0]  t_word;

    typedef enum logic [1:0] {
        KIND_URL    = 2'd0,
        KIND_HOST   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_item;

    // one result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
        logic       method;
    } t_result;

    // configuration register indexes
    localparam logic CFG_MAX_URL  = 1'b0;
    localparam logic CFG_MAX_HOST = 1'b1;

    localparam t_len LEN_RESET = 11'd1024;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] KEEP_MAX = 3'd4;

    localparam t_word WORD_GET  = 32'h0054_4547;
    localparam t_word WORD_POST = 32'h5453_4F50;
    localparam t_word WORD_HOST = 32'h7473_6F48;

endpackage
`default_nettype wire

/* rtl/core/hrhp_in_stage.sv */
// Input register: holds one item ahead of the parse logic.
`default_nettype none
module hrhp_in_stage (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  hrhp_pkg::t_item i_item,
    input  wire             i_take,
    output logic            o_valid,
    output hrhp_pkg::t_item o_item
);
    import hrhp_pkg::*;

    logic  r_valid;
    t_item r_item;

    // refill when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/hrhp_parse_fsm.sv */
// Parse state machine: phase, kept method and key characters, field length.
`default_nettype none
module hrhp_parse_fsm (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  hrhp_pkg::t_item   i_item,
    input  wire               i_fire,
    input  hrhp_pkg::t_len    i_max_url,
    input  hrhp_pkg::t_len    i_max_host,
    output logic              o_res_valid,
    output hrhp_pkg::t_result o_res
);
    import hrhp_pkg::*;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_URL    = 3'd1,
        PH_LINE   = 3'd2,
        PH_KEY    = 3'd3,
        PH_SKIP   = 3'd4,
        PH_HOST   = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    t_word      r_mchars, n_mchars;
    logic [2:0] r_mcnt, n_mcnt;
    t_word      r_kchars, n_kchars;
    logic [2:0] r_kcnt, n_kcnt;
    t_len       r_len, n_len;
    logic       r_cr, n_cr;

    logic [7:0] c;
    logic       is_get, is_post, is_host;

    assign c       = i_item.data_byte;
    assign is_get  = (r_mcnt == 3'd3) && (r_mchars == WORD_GET);
    assign is_post = (r_mcnt == KEEP_MAX) && (r_mchars == WORD_POST);
    assign is_host = (r_kcnt == KEEP_MAX) && (r_kchars == WORD_HOST);

    always_comb begin
        n_phase     = r_phase;
        n_mchars    = r_mchars;
        n_mcnt      = r_mcnt;
        n_kchars    = r_kchars;
        n_kcnt      = r_kcnt;
        n_len       = r_len;
        n_cr        = r_cr;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_URL, byte_value: 8'h00, method: 1'b0};

        if (i_item.stream_end) begin
            n_phase     = PH_METHOD;
            n_mchars    = '0;
            n_mcnt      = '0;
            n_kchars    = '0;
            n_kcnt      = '0;
            n_len       = '0;
            n_cr        = 1'b0;
            o_res_valid = 1'b1;
            o_res.kind  = KIND_REJECT;
        end else begin
            case (r_phase)
                PH_URL: begin
                    if (c == CH_SPACE) begin
                        n_phase = PH_LINE;
                        n_cr    = 1'b0;
                    end else if (r_len < i_max_url) begin
                        n_len            = r_len + t_len'(1);
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_URL;
                        o_res.byte_value = c;
                    end
                end
                PH_LINE: begin
                    // line ends at the first LF right after a CR
                    if (r_cr && (c == CH_LF)) begin
                        n_phase = PH_KEY;
                        n_cr    = 1'b0;
                    end else begin
                        n_cr = (c == CH_CR);
                    end
                end
                PH_KEY: begin
                    if (c == CH_COLON) begin
                        n_phase = PH_SKIP;
                    end else if (r_kcnt < KEEP_MAX) begin
                        n_kchars[r_kcnt[1:0]] = c;
                        n_kcnt                = r_kcnt + 3'd1;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_HOST;
                    n_len   = '0;
                end
                PH_HOST: begin
                    if (c == CH_CR) begin
                        n_phase     = PH_METHOD;
                        n_mchars    = '0;
                        n_mcnt      = '0;
                        n_kchars    = '0;
                        n_kcnt      = '0;
                        n_len       = '0;
                        n_cr        = 1'b0;
                        o_res_valid = 1'b1;
                        if ((is_get || is_post) && is_host) begin
                            o_res.kind   = KIND_ACCEPT;
                            o_res.method = is_post;
                        end else begin
                            o_res.kind = KIND_REJECT;
                        end
                    end else if (r_len < i_max_host) begin
                        n_len            = r_len + t_len'(1);
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_HOST;
                        o_res.byte_value = c;
                    end
                end
                default: begin
                    // method phase; unused codes behave the same
                    n_phase = PH_METHOD;
                    if (c == CH_SPACE) begin
                        n_phase = PH_URL;
                        n_len   = '0;
                    end else if (r_mcnt < KEEP_MAX) begin
                        n_mchars[r_mcnt[1:0]] = c;
                        n_mcnt                = r_mcnt + 3'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_METHOD;
            r_mchars <= '0;
            r_mcnt   <= '0;
            r_kchars <= '0;
            r_kcnt   <= '0;
            r_len    <= '0;
            r_cr     <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_mchars <= n_mchars;
            r_mcnt   <= n_mcnt;
            r_kchars <= n_kchars;
            r_kcnt   <= n_kcnt;
            r_len    <= n_len;
            r_cr     <= n_cr;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/hrhp_out_stage.sv */
// Result register: holds one result until the sink takes it.
`default_nettype none
module hrhp_out_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  hrhp_pkg::t_result i_res,
    input  wire               i_ready,
    output logic              o_valid,
    output hrhp_pkg::t_result o_res
);
    import hrhp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/http_request_head_parser_unit.sv */
// Top level of the HTTP request head parser.
`default_nettype none
`include "http_request_head_parser_unit_assert.svh"
// Streams an HTTP request one byte per item and walks method, URL, rest of
// the request line, header key, one skipped byte after the colon, and host.
// URL and host bytes are passed on as they arrive (kind 0 and 1) up to the
// configured length limits; the CR that ends the host gives a verdict
// (kind 2 accepted with method 0 GET / 1 POST, kind 3 rejected), and so does
// an item with tlast set, after which parsing restarts. One item is taken
// every clock: an input register feeds combinational parse logic that
// writes a result register, and the only stall comes from the sink
// holding m_axis_tready low while the result register is full and the
// held item would produce a result. Limit writes land in registers first.
module http_request_head_parser_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // stream_end
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] byte_value
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] method
    // configuration
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,    // 0 max_url_length, 1 max_host_length
    input  wire  [10:0] i_cfg_data
);
    import hrhp_pkg::*;

    t_len    r_max_url;
    t_len    r_max_host;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // length limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_url  <= LEN_RESET;
            r_max_host <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_URL:  r_max_url  <= i_cfg_data;
                CFG_MAX_HOST: r_max_host <= i_cfg_data;
                default:      r_max_url  <= r_max_url;
            endcase
        end
    end

    assign in_item.data_byte  = s_axis_tdata;
    assign in_item.stream_end = s_axis_tlast;

    hrhp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // held item moves on unless it has a result and the result slot stays full
    assign fire = held_valid && (!res_valid || !m_axis_tvalid || m_axis_tready);

    hrhp_parse_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (held_item),
        .i_fire      (fire),
        .i_max_url   (r_max_url),
        .i_max_host  (r_max_host),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hrhp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.byte_value;
    assign m_axis_tuser = {out_res.method, out_res.kind};

    `HRHP_ASSERT_NOW(a_full_blocks_input, held_valid && !fire, !s_axis_tready)
    `HRHP_ASSERT_NEXT(a_result_lands, fire && res_valid, m_axis_tvalid)
    `HRHP_ASSERT_NOW(a_verdict_no_byte, m_axis_tvalid && out_res.kind[1], m_axis_tdata == 8'h00)
    `HRHP_ASSERT_NOW(a_method_on_accept, m_axis_tvalid && out_res.kind != KIND_ACCEPT, !out_res.method)

endmodule
`default_nettype wire

/* test/tb_http_request_head_parser_unit.sv */
// Self-checking testbench for the HTTP request head parser: random requests, limits, stalls.
`timescale 1ns / 100ps
module tb_http_request_head_parser_unit;
    import hrhp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;   // long output stall, fills the pipe
    localparam int SETTLE = 6;          // covers the input and result registers with margin

    // parser phases, in the order a well-formed request walks them
    typedef enum logic [2:0] {
        PH_METHOD, PH_URL, PH_LINE, PH_KEY, PH_SKIP, PH_HOST
    } t_phase;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;      // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;       // stream_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // [7:0] byte_value
    logic [2:0]  m_axis_tuser;              // [1:0] kind, [2] method
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_MAX_URL;
    logic [10:0] i_cfg_data = 11'd0;

    http_request_head_parser_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------
    // Shadow parser: state, limits and the results it has promised
    // ---------------------------------------------------------------
    t_phase     ph;
    t_word      method_word, key_word;
    logic [2:0] method_cnt, key_cnt;
    t_len       field_len;
    logic       cr_seen;
    t_len       url_limit = LEN_RESET;
    t_len       host_limit = LEN_RESET;

    t_result    awaited_results[$];     // oldest first
    t_item      request_bytes[$];       // items not yet put on the bus
    logic [7:0] draft[$];               // request under construction

    string odd_methods[5] = '{"POSTX", "GE", "PUT", "post", "GETS"};
    string odd_keys[5]    = '{"host", "Hos", "Hostt", "Hxst", "HOST"};

    int send_idle_pct = 16;
    int recv_idle_pct = 55;
    logic stall_go = 1'b0;
    int stall_left = 0;

    int items_taken = 0;
    int cycle_count = 0;
    int unsigned mismatch_count = 0;
    int url_seen = 0, host_seen = 0, accept_seen = 0, post_seen = 0, reject_seen = 0;

    function automatic void restart_parser();
        ph = PH_METHOD;
        method_word = '0;
        method_cnt = '0;
        key_word = '0;
        key_cnt = '0;
        field_len = '0;
        cr_seen = 1'b0;
    endfunction

    function automatic void promise(t_kind k, logic [7:0] b, logic m);
        t_result r;
        r.kind = k;
        r.byte_value = b;
        r.method = m;
        awaited_results.push_back(r);
    endfunction

    // One accepted item through the shadow parser.
    function automatic void parse_byte(logic [7:0] b, logic fin);
        logic is_get, is_post, is_host;
        if (fin) begin
            // end of stream rejects from any phase
            restart_parser();
            promise(KIND_REJECT, 8'h00, 1'b0);
            return;
        end
        case (ph)
            PH_URL: begin
                if (b == CH_SPACE) begin
                    ph = PH_LINE;
                    cr_seen = 1'b0;
                end else if (field_len < url_limit) begin
                    field_len = field_len + 1'b1;
                    promise(KIND_URL, b, 1'b0);
                end
            end
            PH_LINE: begin
                // only LF right after CR closes the line; CR CR stays pending
                if (cr_seen && b == CH_LF) begin
                    ph = PH_KEY;
                    cr_seen = 1'b0;
                end else begin
                    cr_seen = (b == CH_CR);
                end
            end
            PH_KEY: begin
                if (b == CH_COLON) begin
                    ph = PH_SKIP;
                end else if (key_cnt < KEEP_MAX) begin
                    key_word[key_cnt[1:0]] = b;
                    key_cnt = key_cnt + 1'b1;
                end
            end
            PH_SKIP: begin
                ph = PH_HOST;
                field_len = '0;
            end
            PH_HOST: begin
                if (b == CH_CR) begin
                    is_get  = (method_cnt == 3'd3) && (method_word == WORD_GET);
                    is_post = (method_cnt == 3'd4) && (method_word == WORD_POST);
                    is_host = (key_cnt == 3'd4) && (key_word == WORD_HOST);
                    restart_parser();
                    if ((is_get || is_post) && is_host) begin
                        promise(KIND_ACCEPT, 8'h00, is_post);
                    end else begin
                        promise(KIND_REJECT, 8'h00, 1'b0);
                    end
                end else if (field_len < host_limit) begin
                    field_len = field_len + 1'b1;
                    promise(KIND_HOST, b, 1'b0);
                end
            end
            default: begin
                ph = PH_METHOD;
                if (b == CH_SPACE) begin
                    ph = PH_URL;
                    field_len = '0;
                end else if (method_cnt < KEEP_MAX) begin
                    method_word[method_cnt[1:0]] = b;
                    method_cnt = method_cnt + 1'b1;
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic logic [7:0] rand_except(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == avoid) b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic void queue_item(logic [7:0] b, logic fin);
        t_item it;
        it.data_byte = b;
        it.stream_end = fin;
        request_bytes.push_back(it);
    endfunction

    // byte is don't-care on end of stream, so randomize it
    function automatic void queue_end();
        queue_item(8'($urandom_range(255)), 1'b1);
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endfunction

    // Move the draft to the send queue; a broken one is cut short by end of stream.
    function automatic void flush_draft(bit may_cut);
        int cut;
        cut = draft.size();
        if (may_cut && $urandom_range(9) == 0) cut = $urandom_range(draft.size() - 1);
        foreach (draft[i]) if (i < cut) queue_item(draft[i], 1'b0);
        if (cut < draft.size()) queue_end();
        draft.delete();
    endfunction

    function automatic void queue_request();
        int n;
        case ($urandom_range(9))
            0, 1, 2, 3: push_str("GET");
            4, 5, 6:    push_str("POST");
            7:          push_str(odd_methods[$urandom_range(4)]);
            default:    repeat ($urandom_range(6)) draft.push_back(rand_except(CH_SPACE));
        endcase
        draft.push_back(CH_SPACE);
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        repeat (n) draft.push_back(rand_except(CH_SPACE));
        draft.push_back(CH_SPACE);
        // rest of the request line, now and then with a stray CR
        repeat ($urandom_range(4)) draft.push_back(rand_except(CH_CR));
        if ($urandom_range(3) == 0) begin
            draft.push_back(CH_CR);
            draft.push_back(rand_except(CH_LF));
        end
        draft.push_back(CH_CR);
        draft.push_back(CH_LF);
        case ($urandom_range(4))
            0, 1, 2: push_str("Host");
            3:       push_str(odd_keys[$urandom_range(4)]);
            default: repeat ($urandom_range(6)) draft.push_back(rand_except(CH_COLON));
        endcase
        draft.push_back(CH_COLON);
        draft.push_back(8'($urandom_range(255)));   // dropped whatever it is
        n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
        repeat (n) draft.push_back(rand_except(CH_CR));
        draft.push_back(CH_CR);
        flush_draft(1'b1);
    endfunction

    function automatic void queue_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(6) == 0) queue_end();
            else queue_item(8'($urandom_range(255)), 1'b0);
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued items, feeds the shadow parser on acceptance
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                parse_byte(s_axis_tdata, s_axis_tlast);
                items_taken <= items_taken + 1;
            end
            if (request_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = request_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data_byte;
                s_axis_tlast  <= nxt.stream_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks results in order, owns the output hold-off count
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_proc
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = t_kind'(m_axis_tuser[1:0]);
                got.byte_value = m_axis_tdata;
                got.method = m_axis_tuser[2];
                case (got.kind)
                    KIND_URL:    url_seen <= url_seen + 1;
                    KIND_HOST:   host_seen <= host_seen + 1;
                    KIND_ACCEPT: begin
                        accept_seen <= accept_seen + 1;
                        if (got.method) post_seen <= post_seen + 1;
                    end
                    default:     reject_seen <= reject_seen + 1;
                endcase
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected item: kind %0d byte %02h method %0d",
                                 got.kind, got.byte_value, got.method);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.kind != want.kind || got.byte_value != want.byte_value ||
                        got.method != want.method) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected kind %0d byte %02h method %0d, %s %0d %02h %0d",
                                     want.kind, want.byte_value, want.method, "got",
                                     got.kind, got.byte_value, got.method);
                    end
                end
            end
            if (stall_go) stall_left <= HOLD_CYCLES;
            else if (stall_left != 0) stall_left <= stall_left - 1;
            m_axis_tready <= !stall_go && stall_left == 0 &&
                             ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_http_request_head_parser_unit: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    // Sender stops until every promised result is back; the settle time
    // covers items still in flight that give no result.
    task automatic wait_drained();
        while (request_bytes.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limits(t_len url, t_len host);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_URL;
        i_cfg_data  <= url;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_HOST;
        i_cfg_data  <= host;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        url_limit = url;
        host_limit = host;
    endtask

    task automatic run_phase(t_len url, t_len host, int count, int send_pct, int recv_pct,
                             bit hold);
        write_limits(url, host);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        while (request_bytes.size() < count) begin
            if ($urandom_range(6) == 0) queue_noise();
            else queue_request();
        end
        if (hold) begin
            // sink goes quiet while the source keeps pushing
            @(posedge i_clk);
            stall_go <= 1'b1;
            @(posedge i_clk);
            stall_go <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        restart_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: end of stream while idle, a long POST method kept as POST
        // with extreme URL bytes, CR CR LF line end, CR as the skipped byte,
        // then a GET cut off by end of stream in the URL phase
        queue_end();
        push_str("POSTX");
        draft.push_back(CH_SPACE);
        draft.push_back(8'h00);
        draft.push_back(8'hFF);
        draft.push_back(CH_SPACE);
        draft.push_back(CH_CR);
        draft.push_back(CH_CR);
        draft.push_back(CH_LF);
        push_str("Host");
        draft.push_back(CH_COLON);
        draft.push_back(CH_CR);
        draft.push_back(8'h80);
        draft.push_back(CH_CR);
        push_str("GET ");
        draft.push_back(8'h7F);
        flush_draft(1'b0);
        queue_end();
        wait_drained();

        // random traffic across limit settings and idle mixes
        run_phase(11'd0,    11'd0,    300, 16, 55, 1'b0);
        run_phase(11'd2047, 11'd2047, 300, 16, 55, 1'b1);
        run_phase(11'd3,    11'd2,    350, 55, 16, 1'b0);
        run_phase(t_len'($urandom_range(16)), t_len'($urandom_range(16)), 350, 55, 16, 1'b0);
        run_phase(LEN_RESET, 11'd1,   400, 0,  0,  1'b0);

        $display("covered %0d input items over six limit settings incl. 0 and 2047, %s",
                 items_taken, "a long output stall and three idle mixes");
        $display("results seen: %0d url, %0d host, %0d accepted (%0d post), %0d rejected",
                 url_seen, host_seen, accept_seen, post_seen, reject_seen);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("tb_http_request_head_parser_unit: clean");
        end else begin
            $display("tb_http_request_head_parser_unit: errors");
        end
        $finish;
    end

endmodule

/* http_request_head_parser_unit.f */
+incdir+rtl/core
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_in_stage.sv
rtl/core/hrhp_parse_fsm.sv
rtl/core/hrhp_out_stage.sv
rtl/core/http_request_head_parser_unit.sv
test/tb_http_request_head_parser_unit.sv
